/* rtl/salc_pkg.sv */
// Shared types and constants of the set-associative LRU cache simulator.
package salc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_HIT   = 2'd0,
    RES_FILL  = 2'd1,
    RES_EVICT = 2'd2
  } outcome_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS        = 2'd2
  } cfg_idx_t;

  localparam int CFG_SET_W    = 3;
  localparam int CFG_OFFSET_W = 6;
  localparam int CFG_WAYS_W   = 4;

  localparam logic [CFG_SET_W-1:0]    SET_BITS_RST    = 3'd4;
  localparam logic [CFG_OFFSET_W-1:0] OFFSET_BITS_RST = 6'd4;
  localparam logic [CFG_WAYS_W-1:0]   WAYS_RST        = 4'd1;

  localparam int OP_W        = 2;
  localparam int CNT_W       = 32;
  localparam int OUT_FIELD_W = 2 + 1 + 3 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

/* rtl/salc_front.sv */
// Front end: configuration registers and address split of each access.
module salc_front import salc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((OP_W+ADDR_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                               push_valid,
  input  logic                               push_ready,
  output op_t                                push_op,
  output logic [((MAX_SET_BITS>0)?MAX_SET_BITS:1)-1:0] push_set,
  output logic [ADDR_WIDTH-1:0]              push_tag,
  output logic [$clog2(MAX_WAYS+1)-1:0]      push_ways
);

  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAYS_W = $clog2(MAX_WAYS + 1);
  localparam int SB_W   = ($clog2(MAX_SET_BITS + 1) > CFG_SET_W) ?
                          $clog2(MAX_SET_BITS + 1) : CFG_SET_W;
  localparam int WC_W   = (WAYS_W > CFG_WAYS_W) ? WAYS_W : CFG_WAYS_W;
  localparam int SH_W   = ((CFG_OFFSET_W > SB_W) ? CFG_OFFSET_W : SB_W) + 1;
  localparam logic [SB_W-1:0] S_MAX = SB_W'(MAX_SET_BITS);
  localparam logic [WC_W-1:0] W_MAX = WC_W'(MAX_WAYS);

  logic [CFG_SET_W-1:0]    set_bits_r;
  logic [CFG_OFFSET_W-1:0] offset_bits_r;
  logic [CFG_WAYS_W-1:0]   ways_r;

  logic [SB_W-1:0]       set_ext;
  logic [SB_W-1:0]       s_eff;
  logic [WC_W-1:0]       ways_ext;
  logic [SH_W-1:0]       tag_shift;
  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH-1:0] addr_off;
  logic [SET_W-1:0]      set_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= SET_BITS_RST;
      offset_bits_r <= OFFSET_BITS_RST;
      ways_r        <= WAYS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SET_BITS:    set_bits_r    <= cfg_data[CFG_SET_W-1:0];
        CFG_OFFSET_BITS: offset_bits_r <= cfg_data[CFG_OFFSET_W-1:0];
        CFG_WAYS:        ways_r        <= cfg_data[CFG_WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    set_ext   = SB_W'(set_bits_r);
    s_eff     = (set_ext > S_MAX) ? S_MAX : set_ext;
    ways_ext  = WC_W'(ways_r);
    addr      = in_tdata[OP_W +: ADDR_WIDTH];
    addr_off  = addr >> offset_bits_r;
    tag_shift = SH_W'(offset_bits_r) + SH_W'(s_eff);
    set_mask  = ~({SET_W{1'b1}} << s_eff);
    push_op   = op_t'(in_tdata[OP_W-1:0]);
    push_set  = addr_off[SET_W-1:0] & set_mask;
    push_tag  = addr >> tag_shift;
    if (ways_ext == '0) begin
      push_ways = WAYS_W'(1);
    end else if (ways_ext > W_MAX) begin
      push_ways = WAYS_W'(MAX_WAYS);
    end else begin
      push_ways = ways_ext[WAYS_W-1:0];
    end
  end

  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

endmodule

/* rtl/salc_fifo.sv */
// Short queue between the front end and the cache back end.
module salc_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [W-1:0]     entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

/* rtl/salc_back.sv */
// Back end: set memory read-modify-write, LRU update, counters and result register.
module salc_back import salc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  op_t                           q_op,
  input  logic [((MAX_SET_BITS>0)?MAX_SET_BITS:1)-1:0] q_set,
  input  logic [ADDR_WIDTH-1:0]         q_tag,
  input  logic [$clog2(MAX_WAYS+1)-1:0] q_ways,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_TDATA_W-1:0]        out_tdata
);

  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ROWS   = 1 << SET_W;
  localparam int WAYS_W = $clog2(MAX_WAYS + 1);
  localparam int IDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
  localparam int PAD_W  = OUT_TDATA_W - OUT_FIELD_W;

  typedef enum logic {S_FETCH, S_EXEC} state_t;

  state_t                 state_r;
  op_t                    op_r;
  logic [SET_W-1:0]       set_r;
  logic [ADDR_WIDTH-1:0]  tag_r;
  logic [WAYS_W-1:0]      ways_r;

  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem [ROWS];
  logic [MAX_WAYS-1:0]                 vld_mem [ROWS];
  logic [MAX_WAYS-1:0][AGE_W-1:0]      age_mem [ROWS];
  logic [ROWS-1:0]                     row_ok_r;

  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag_r;
  logic [MAX_WAYS-1:0]                 rd_vld_r;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      rd_age_r;
  logic                                rd_row_ok_r;

  logic [CNT_W-1:0]       hit_r;
  logic [CNT_W-1:0]       miss_r;
  logic [CNT_W-1:0]       evict_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [MAX_WAYS-1:0]                 cur_vld;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      cur_age;
  logic [MAX_WAYS-1:0]                 in_use;
  logic [MAX_WAYS-1:0]                 cand;
  logic                                found;
  logic [IDX_W-1:0]                    sel;
  logic [IDX_W-1:0]                    victim;
  logic                                is_hit;
  logic [AGE_W-1:0]                    old_age;
  logic [MAX_WAYS-1:0]                 new_vld;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      new_age;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tag;
  logic                                op_ok;
  logic                                is_mod;
  logic                                fire;
  logic                                rd_en;
  logic                                wr_en;
  outcome_t                            outcome;
  logic [CNT_W-1:0]                    hit_nxt;
  logic [CNT_W-1:0]                    miss_nxt;
  logic [CNT_W-1:0]                    evict_nxt;

  assign q_ready = (state_r == S_FETCH);
  assign rd_en   = (state_r == S_FETCH) && q_valid;
  assign fire    = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign op_ok   = (op_r != OP_NONE);
  assign is_mod  = (op_r == OP_MODIFY);
  assign wr_en   = fire && op_ok;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tag_r <= tag_mem[q_set];
      rd_vld_r <= vld_mem[q_set];
      rd_age_r <= age_mem[q_set];
    end
    if (wr_en) begin
      tag_mem[set_r] <= new_tag;
      vld_mem[set_r] <= new_vld;
      age_mem[set_r] <= new_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r    <= '0;
      rd_row_ok_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_row_ok_r <= row_ok_r[q_set];
      end
      if (wr_en) begin
        row_ok_r[set_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    cur_vld = rd_row_ok_r ? rd_vld_r : '0;
    cur_age = rd_row_ok_r ? rd_age_r : '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (WAYS_W'(w) < ways_r);
      cand[w]   = in_use[w] && (!cur_vld[w] || (rd_tag_r[w] == tag_r));
    end
    found = 1'b0;
    sel   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!found && cand[w]) begin
        found = 1'b1;
        sel   = IDX_W'(w);
      end
    end
    victim = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (cur_age[w] > cur_age[victim])) begin
        victim = IDX_W'(w);
      end
    end
    if (!found) begin
      sel = victim;
    end
    is_hit  = found && cur_vld[sel];
    old_age = cur_age[sel];
    for (int v = 0; v < MAX_WAYS; v++) begin
      new_age[v] = cur_age[v];
      if (IDX_W'(v) == sel) begin
        new_age[v] = '0;
      end else if (in_use[v] && cur_vld[v] && (!is_hit || (cur_age[v] < old_age)) &&
                   (cur_age[v] < AGE_MAX)) begin
        new_age[v] = cur_age[v] + 1'b1;
      end
    end
    new_vld      = cur_vld;
    new_vld[sel] = 1'b1;
    new_tag      = rd_tag_r;
    new_tag[sel] = tag_r;
    if (!op_ok || is_hit) begin
      outcome = RES_HIT;
    end else if (found) begin
      outcome = RES_FILL;
    end else begin
      outcome = RES_EVICT;
    end
    hit_nxt   = hit_r + CNT_W'(op_ok && is_hit) + CNT_W'(is_mod);
    miss_nxt  = miss_r + CNT_W'(op_ok && !is_hit);
    evict_nxt = evict_r + CNT_W'(op_ok && !found);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FETCH;
      out_valid_r <= 1'b0;
      hit_r       <= '0;
      miss_r      <= '0;
      evict_r     <= '0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_FETCH: begin
          if (q_valid) begin
            op_r    <= q_op;
            set_r   <= q_set;
            tag_r   <= q_tag;
            ways_r  <= q_ways;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            hit_r       <= hit_nxt;
            miss_r      <= miss_nxt;
            evict_r     <= evict_nxt;
            out_data_r  <= {{PAD_W{1'b0}}, evict_nxt, miss_nxt, hit_nxt, is_mod, outcome};
            state_r     <= S_FETCH;
          end
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op_ok && !found) |=>
      ((evict_r == $past(evict_r) + 1'b1) && (miss_r == $past(miss_r) + 1'b1)))
    else $error("eviction not counted as a miss");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire))
    else $error("result raised without an executed access");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("result changed while stalled");

endmodule

/* rtl/set_assoc_lru_cache_sim.sv */
// Top level of the set-associative LRU cache simulator.
// Usage:
//   in_*  : one access per transaction. in_tdata = {address, operation}, operation in
//           the low two bits (load, store, modify; code 3 changes nothing).
//   out_* : one result per access, in order. out_tdata carries outcome, extra_hit and
//           the running hit, miss and eviction totals after that access.
//   cfg_* : register writes (set index bits, offset bits, ways in use), always ready;
//           write only while no access is in flight.
// Timing:
//   An access enters a two-entry queue; the back end reads the set row from the line
//   memory in its fetch state and compares, updates LRU and writes the row back in its
//   execute state, which waits while a result is held. One memory read-modify-write per
//   access: the back end takes no new access from the queue until it has executed the last.
// Reset:
//   rst_n low clears counters, queue and one valid flag per set row; rows read as empty
//   until first written, so no clearing pass is needed. Configuration returns to
//   4 set bits, 4 offset bits, 1 way.
// Stall:
//   The result register holds while out_tready is low; the back end stops and the
//   queue absorbs up to two further accesses before in_tready drops.
module set_assoc_lru_cache_sim import salc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // fields from bit 0: operation, address, zero pad
  input  logic [((OP_W+ADDR_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // fields from bit 0: outcome, extra_hit, hit_total, miss_total, eviction_total, zero pad
  output logic [OUT_TDATA_W-1:0]               out_tdata
);

  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAYS_W = $clog2(MAX_WAYS + 1);
  localparam int QW     = OP_W + ADDR_WIDTH + SET_W + WAYS_W;

  logic                  push_valid;
  logic                  push_ready;
  op_t                   push_op;
  logic [SET_W-1:0]      push_set;
  logic [ADDR_WIDTH-1:0] push_tag;
  logic [WAYS_W-1:0]     push_ways;
  logic [QW-1:0]         q_wr_data;
  logic [QW-1:0]         q_rd_data;
  logic                  q_valid;
  logic                  q_ready;

  salc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .push_set   (push_set),
    .push_tag   (push_tag),
    .push_ways  (push_ways)
  );

  assign q_wr_data = {push_ways, push_set, push_tag, push_op};

  salc_fifo #(
    .W     (QW),
    .DEPTH (2)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_rd_data)
  );

  salc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_op       (op_t'(q_rd_data[OP_W-1:0])),
    .q_set      (q_rd_data[OP_W+ADDR_WIDTH +: SET_W]),
    .q_tag      (q_rd_data[OP_W +: ADDR_WIDTH]),
    .q_ways     (q_rd_data[OP_W+ADDR_WIDTH+SET_W +: WAYS_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* sim/tb.sv */
// Self-checking testbench for the set-associative LRU cache simulator.
`timescale 1ns / 100ps

module tb;
  import salc_pkg::*;

  localparam int SET_BITS_MAX = 6;
  localparam int WAYS_MAX     = 8;
  localparam int LINES        = (1 << SET_BITS_MAX) * WAYS_MAX;
  localparam int IN_W         = ((OP_W + 64 + 7) / 8) * 8;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 150;

  typedef struct {
    op_t         op;
    logic [63:0] addr;
  } access_t;

  typedef struct {
    outcome_t    outcome;
    logic        extra_hit;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } report_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  set_assoc_lru_cache_sim dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  logic [CFG_SET_W-1:0]    cur_set_bits;
  logic [CFG_OFFSET_W-1:0] cur_off_bits;
  logic [CFG_WAYS_W-1:0]   cur_ways;

  logic        line_valid [LINES];
  logic [63:0] line_tag   [LINES];
  logic [2:0]  line_age   [LINES];
  logic [31:0] hit_count, miss_count, evict_count;

  access_t     access_q[$];
  report_t     result_q[$];
  logic [63:0] tag_pool [10];

  int errors      = 0;
  int n_in        = 0;
  int n_out       = 0;
  int n_settings  = 0;
  int stat_hit    = 0;
  int stat_fill   = 0;
  int stat_evict  = 0;
  int stat_noop   = 0;
  logic in_taken  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] low_mask(int w);
    return (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] shr(logic [63:0] x, int n);
    return (n >= 64) ? 64'd0 : (x >> n);
  endfunction

  function automatic int set_width();
    return (cur_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : int'(cur_set_bits);
  endfunction

  function automatic int way_count();
    return (cur_ways == 0) ? 1 : ((cur_ways > WAYS_MAX) ? WAYS_MAX : int'(cur_ways));
  endfunction

  function automatic void promote_way(int base, int ways, int way, int old);
    int v;
    for (v = 0; v < ways; v++) begin
      if (v != way && line_valid[base + v] && int'(line_age[base + v]) < old &&
          int'(line_age[base + v]) < WAYS_MAX - 1)
        line_age[base + v] = line_age[base + v] + 3'd1;
    end
    line_age[base + way] = '0;
  endfunction

  function automatic report_t cache_access(op_t op, logic [63:0] addr);
    report_t     r;
    int          s, ways, base, w, e, victim;
    logic [63:0] tag;
    bit          done;
    r.outcome   = RES_HIT;
    r.extra_hit = 1'b0;
    if (op != OP_NONE) begin
      s     = set_width();
      ways  = way_count();
      base  = int'(shr(addr, int'(cur_off_bits)) & low_mask(s)) * WAYS_MAX;
      tag   = shr(addr, int'(cur_off_bits) + s);
      done  = 1'b0;
      for (w = 0; w < ways && !done; w++) begin
        e = base + w;
        if (line_valid[e] && line_tag[e] == tag) begin
          hit_count++;
          promote_way(base, ways, w, int'(line_age[e]));
          r.outcome = RES_HIT;
          done = 1'b1;
        end else if (!line_valid[e]) begin
          miss_count++;
          line_valid[e] = 1'b1;
          line_tag[e]   = tag;
          promote_way(base, ways, w, WAYS_MAX);
          r.outcome = RES_FILL;
          done = 1'b1;
        end
      end
      if (!done) begin
        victim = 0;
        for (w = 1; w < ways; w++)
          if (line_age[base + w] > line_age[base + victim]) victim = w;
        line_tag[base + victim] = tag;
        promote_way(base, ways, victim, WAYS_MAX);
        miss_count++;
        evict_count++;
        r.outcome = RES_EVICT;
      end
      if (op == OP_MODIFY) begin
        hit_count++;
        r.extra_hit = 1'b1;
      end
    end
    r.hits   = hit_count;
    r.misses = miss_count;
    r.evicts = evict_count;
    return r;
  endfunction

  always @(posedge clk) begin
    report_t exp_r, got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        exp_r = cache_access(op_t'(in_tdata[1:0]), in_tdata[65:2]);
        result_q.push_back(exp_r);
        n_in++;
        if (in_tdata[1:0] == OP_NONE) stat_noop++;
        else if (exp_r.outcome == RES_HIT) stat_hit++;
        else if (exp_r.outcome == RES_FILL) stat_fill++;
        else stat_evict++;
      end
      if (out_tvalid && out_tready) begin
        n_out++;
        got.outcome   = outcome_t'(out_tdata[1:0]);
        got.extra_hit = out_tdata[2];
        got.hits      = out_tdata[34:3];
        got.misses    = out_tdata[66:35];
        got.evicts    = out_tdata[98:67];
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: %0d %0b %0d/%0d/%0d",
                   $time, got.outcome, got.extra_hit, got.hits, got.misses, got.evicts);
        end else begin
          exp_r = result_q.pop_front();
          if (got.outcome !== exp_r.outcome || got.extra_hit !== exp_r.extra_hit ||
              got.hits !== exp_r.hits || got.misses !== exp_r.misses ||
              got.evicts !== exp_r.evicts) begin
            errors++;
            $display("%0t: mismatch exp %0d %0b %0d/%0d/%0d, got %0d %0b %0d/%0d/%0d",
                     $time, exp_r.outcome, exp_r.extra_hit, exp_r.hits, exp_r.misses,
                     exp_r.evicts, got.outcome, got.extra_hit, got.hits, got.misses,
                     got.evicts);
          end
        end
      end
    end
  end

  int      burst_left = 1;
  int      gap_left   = 0;
  access_t drv_item;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0 || access_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        drv_item = access_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(IN_W - OP_W - 64){1'b0}}, drv_item.addr, drv_item.op};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  int rx_mode      = 0;
  int rx_left      = 0;
  int rx_tick      = 0;
  int hold_left    = 0;
  int next_hold_at = 250;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (n_out >= next_hold_at && access_q.size() > 20) begin
      hold_left    = HOLD_CYCLES;
      next_hold_at = next_hold_at + 600;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 1);
        2:       out_tready <= (rx_tick % 3 == 0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SET_BITS:    cur_set_bits = val[CFG_SET_W-1:0];
      CFG_OFFSET_BITS: cur_off_bits = val[CFG_OFFSET_W-1:0];
      default:         cur_ways     = val[CFG_WAYS_W-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int set_bits, int off_bits, int ways);
    write_reg(CFG_SET_BITS, CFG_DATA_W'(set_bits));
    write_reg(CFG_OFFSET_BITS, CFG_DATA_W'(off_bits));
    write_reg(CFG_WAYS, CFG_DATA_W'(ways));
    n_settings++;
  endtask

  task automatic settle();
    while (access_q.size() != 0 || in_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void add_access(op_t op, logic [63:0] addr);
    access_t a;
    a.op   = op;
    a.addr = addr;
    access_q.push_back(a);
  endfunction

  function automatic void fill_random(int count);
    int          i, pick, s, off;
    logic [63:0] set_sel, tag, addr;
    op_t         op;
    for (i = 0; i < 10; i++)
      tag_pool[i] = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 15))
                                                : {$urandom, $urandom};
    s   = set_width();
    off = int'(cur_off_bits);
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        addr = {$urandom, $urandom};
      end else begin
        set_sel = (pick < 20) ? 64'($urandom) : 64'($urandom_range(0, 3));
        tag     = tag_pool[$urandom_range(0, way_count() + 1)];
        addr    = ((off + s >= 64) ? 64'd0 : (tag << (off + s))) |
                  ((set_sel & low_mask(s)) << off) |
                  ({$urandom, $urandom} & low_mask(off));
      end
      if ($urandom_range(0, 19) == 0) op = OP_NONE;
      else op = op_t'($urandom_range(0, 2));
      add_access(op, addr);
    end
  endfunction

  int phase_set [8] = '{0, 6, 7, 3, 2, 6, 1, 5};
  int phase_off [8] = '{0, 32, 63, 5, 40, 0, 12, 60};
  int phase_ways[8] = '{1, 8, 15, 0, 3, 8, 9, 4};

  initial begin : stimulus
    int i;
    for (i = 0; i < LINES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_age[i]   = '0;
    end
    hit_count    = '0;
    miss_count   = '0;
    evict_count  = '0;
    cur_set_bits = SET_BITS_RST;
    cur_off_bits = OFFSET_BITS_RST;
    cur_ways     = WAYS_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    add_access(OP_LOAD,   64'h0);
    add_access(OP_LOAD,   64'hF);
    add_access(OP_STORE,  64'h10);
    add_access(OP_MODIFY, 64'h10);
    add_access(OP_MODIFY, 64'h100);
    add_access(OP_LOAD,   64'h0);
    add_access(OP_NONE,   64'hFFFF_FFFF_FFFF_FFFF);
    add_access(OP_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
    add_access(OP_STORE,  64'hFFFF_FFFF_FFFF_FFFF);
    add_access(OP_LOAD,   64'h8000_0000_0000_0000);
    add_access(OP_STORE,  64'h5555_5555_5555_5555);
    add_access(OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
    settle();

    set_config(2, 3, 4);
    for (i = 1; i <= 4; i++) add_access(OP_LOAD, 64'(i) << 5);
    add_access(OP_LOAD,   64'd1 << 5);
    add_access(OP_LOAD,   64'd5 << 5);
    add_access(OP_STORE,  64'd2 << 5);
    add_access(OP_MODIFY, 64'd1 << 5);
    add_access(OP_LOAD,   64'd4 << 5);
    settle();

    for (i = 0; i < 10; i++) begin
      if (i < 8) set_config(phase_set[i], phase_off[i], phase_ways[i]);
      else set_config($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 15));
      fill_random(PHASE_ITEMS);
      settle();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d accesses over %0d register settings:", n_in, n_settings);
    $display("  %0d hits, %0d fills, %0d evictions, %0d no-ops; %0d results, %0d mismatches.",
             stat_hit, stat_fill, stat_evict, stat_noop, n_out, errors);
    if (errors == 0 && result_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, result_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
